>>> design/triggered_linear_envelope_core_macros.svh
// Assertion helpers used by the checker file of the envelope core.
`ifndef TRIGGERED_LINEAR_ENVELOPE_CORE_MACROS_SVH
`define TRIGGERED_LINEAR_ENVELOPE_CORE_MACROS_SVH

// Clocked property that is switched off while reset is asserted.
`define TLE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tle_checker: property failed");

// Clocked property that must also hold during reset.
`define TLE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tle_checker: property failed");

`endif

>>> design/tle_pkg.sv
package tle_pkg;

  localparam int unsigned MAX_SEGMENTS = 3;
  localparam int unsigned LVL_W        = 24;
  localparam int unsigned LEN_W        = 24;
  localparam int unsigned ACC_W        = 40;
  localparam int unsigned FRAC_SH      = 16;
  localparam int unsigned SEG_W        = 2;
  localparam int unsigned MAG_W        = LVL_W + 1;
  localparam int unsigned DIVD_W       = MAG_W + FRAC_SH;
  localparam int unsigned ADDR_W       = 5;
  localparam int unsigned DATA_W       = 32;

  typedef enum logic [2:0] {
    REG_LEVEL_START   = 3'd0,
    REG_LEVEL_ONE     = 3'd1,
    REG_LEVEL_TWO     = 3'd2,
    REG_LEVEL_THREE   = 3'd3,
    REG_LENGTH_ZERO   = 3'd4,
    REG_LENGTH_ONE    = 3'd5,
    REG_LENGTH_TWO    = 3'd6,
    REG_SEGMENTS_USED = 3'd7
  } tle_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_STEP,
    ST_FIN
  } tle_state_e;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [LEN_W-1:0] divisor;
  } tle_div_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] quot;
  } tle_div_rsp_t;

endpackage

>>> design/tle_div.sv
module tle_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tle_pkg::tle_div_req_t req_i,
  output tle_pkg::tle_div_rsp_t rsp_o
);
  import tle_pkg::*;

  localparam int unsigned STEPS = DIVD_W;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic [DIVD_W-1:0] dq_q, dq_d;
  logic [LEN_W-1:0]  dvs_q;
  logic              neg_q;

  logic [LEN_W:0]    shifted;
  logic [LEN_W:0]    trial;
  logic              fit;
  logic              pos_over;
  logic              neg_over;

  // One restoring step per cycle; quotient bits shift in behind the dividend.
  always_comb begin
    shifted = {rem_q, dq_q[DIVD_W-1]};
    fit     = shifted >= {1'b0, dvs_q};
    trial   = shifted - {1'b0, dvs_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dq_d   = dq_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dq_d   = {req_i.mag, {FRAC_SH{1'b0}}};
    end else if (busy_q) begin
      rem_d = fit ? trial[LEN_W-1:0] : shifted[LEN_W-1:0];
      dq_d  = {dq_q[DIVD_W-2:0], fit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    if (req_i.start) begin
      dvs_q <= req_i.divisor;
      neg_q <= req_i.neg;
    end
  end

  // Sign and clamp the magnitude quotient to the accumulator range.
  always_comb begin
    pos_over = dq_q[DIVD_W-1] | dq_q[ACC_W-1];
    neg_over = dq_q[DIVD_W-1] | (dq_q[ACC_W-1] & (|dq_q[ACC_W-2:0]));
    if (neg_q) begin
      rsp_o.quot = neg_over ? {1'b1, {(ACC_W-1){1'b0}}} : (~dq_q[ACC_W-1:0] + 1'b1);
    end else begin
      rsp_o.quot = pos_over ? {1'b0, {(ACC_W-1){1'b1}}} : dq_q[ACC_W-1:0];
    end
    rsp_o.done = done_q;
  end

endmodule

>>> design/triggered_linear_envelope_core.sv
// A tick without a slope division passes through the STEP and FIN states before its
// result is registered; a tick that starts a segment (trigger or segment change) also
// waits in DIV on the 41-step restoring divider, which computes the new slope one bit
// per cycle. One tick is handled at a time; the next tick is taken once the result is
// registered, even while it waits on the output side.
// Reset: async, active low; all but level_q, play_q and divider data reset at once.
module triggered_linear_envelope_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tle_pkg::ADDR_W-1:0]   paddr,
  input  logic [tle_pkg::DATA_W-1:0]   pwdata,
  output logic [tle_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  // Sample tick input.
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         trigger_i,
  // Envelope result output.
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [tle_pkg::LVL_W-1:0] level_out_o,
  output logic                         playing_o
);
  import tle_pkg::*;

  // Breakpoint levels and segment lengths, packed so a segment number selects them.
  logic [3:0][LVL_W-1:0] lvl_q;
  logic [2:0][LEN_W-1:0] len_q;
  logic [SEG_W-1:0]      seg_used_q;

  // Envelope state.
  tle_state_e        state_q, state_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [ACC_W-1:0]  slope_q, slope_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [SEG_W-1:0]  seg_q, seg_d;
  logic              run_q, run_d;
  logic              post_step_q, post_step_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [LVL_W-1:0]  level_q, level_d;
  logic              play_q, play_d;

  // Control strobes from the sequencer.
  logic              accept;
  logic              div_go;
  logic              out_load;

  // Datapath helpers.
  logic [SEG_W-1:0]  used;
  logic              seg_live;
  logic [LEN_W-1:0]  cur_len;
  logic              cnt_lt;
  logic [SEG_W-1:0]  seg_nxt;
  logic              nxt_live;
  logic              step_div;
  logic [SEG_W-1:0]  div_seg;
  logic [SEG_W-1:0]  div_seg_hi;
  logic [LEN_W-1:0]  div_len;
  logic              div_len_zero;
  logic [MAG_W-1:0]  diff;
  logic [ACC_W:0]    sum;
  logic [ACC_W-1:0]  acc_sat;
  logic              cfg_wr;

  tle_div_req_t      div_req;
  tle_div_rsp_t      div_rsp;

  function automatic logic [LEN_W-1:0] sel_len(input logic [2:0][LEN_W-1:0] l,
                                               input logic [SEG_W-1:0] s);
    logic [LEN_W-1:0] r;
    case (s)
      2'd0:    r = l[0];
      2'd1:    r = l[1];
      2'd2:    r = l[2];
      default: r = '0;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers. pready is tied high, so every access cycle with
  // pwrite set completes a write transaction.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q      <= '0;
      len_q      <= '0;
      seg_used_q <= SEG_W'(1);
    end else if (cfg_wr) begin
      unique case (tle_reg_e'(paddr[4:2]))
        REG_LEVEL_START:   lvl_q[0]   <= pwdata[LVL_W-1:0];
        REG_LEVEL_ONE:     lvl_q[1]   <= pwdata[LVL_W-1:0];
        REG_LEVEL_TWO:     lvl_q[2]   <= pwdata[LVL_W-1:0];
        REG_LEVEL_THREE:   lvl_q[3]   <= pwdata[LVL_W-1:0];
        REG_LENGTH_ZERO:   len_q[0]   <= pwdata[LEN_W-1:0];
        REG_LENGTH_ONE:    len_q[1]   <= pwdata[LEN_W-1:0];
        REG_LENGTH_TWO:    len_q[2]   <= pwdata[LEN_W-1:0];
        REG_SEGMENTS_USED: seg_used_q <= pwdata[SEG_W-1:0];
        default:           lvl_q[0]   <= lvl_q[0];
      endcase
    end
  end

  always_comb begin
    unique case (tle_reg_e'(paddr[4:2]))
      REG_LEVEL_START:   prdata = DATA_W'(lvl_q[0]);
      REG_LEVEL_ONE:     prdata = DATA_W'(lvl_q[1]);
      REG_LEVEL_TWO:     prdata = DATA_W'(lvl_q[2]);
      REG_LEVEL_THREE:   prdata = DATA_W'(lvl_q[3]);
      REG_LENGTH_ZERO:   prdata = DATA_W'(len_q[0]);
      REG_LENGTH_ONE:    prdata = DATA_W'(len_q[1]);
      REG_LENGTH_TWO:    prdata = DATA_W'(len_q[2]);
      REG_SEGMENTS_USED: prdata = DATA_W'(seg_used_q);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath conditions. The segment count is clamped: zero counts as one and
  // anything above the supported maximum counts as the maximum.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (seg_used_q == '0) begin
      used = SEG_W'(1);
    end else if (seg_used_q > SEG_W'(MAX_SEGMENTS)) begin
      used = SEG_W'(MAX_SEGMENTS);
    end else begin
      used = seg_used_q;
    end

    seg_live = run_q && (seg_q < used);
    cur_len  = sel_len(len_q, seg_q);
    cnt_lt   = cnt_q < cur_len;
    seg_nxt  = seg_q + 1'b1;
    nxt_live = seg_nxt < used;
    step_div = seg_live && !cnt_lt && nxt_live;

    // A trigger always computes the slope of the first segment; a segment
    // change computes the slope of the segment that follows.
    div_seg      = (state_q == ST_IDLE) ? '0 : seg_nxt;
    div_seg_hi   = div_seg + 1'b1;
    div_len      = sel_len(len_q, div_seg);
    div_len_zero = (div_len == '0);
    diff         = {lvl_q[div_seg_hi][LVL_W-1], lvl_q[div_seg_hi]}
                 - {lvl_q[div_seg][LVL_W-1], lvl_q[div_seg]};

    // Saturating accumulate: an overflow shows as a disagreement of the two
    // top bits of the widened sum.
    sum = {acc_q[ACC_W-1], acc_q} + {slope_q[ACC_W-1], slope_q};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      acc_sat = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = sum[ACC_W-1:0];
    end
  end

  // The divider works on the magnitude of the level difference; the sign is
  // restored at the end so the quotient truncates toward zero.
  always_comb begin
    div_req.start   = div_go;
    div_req.neg     = diff[MAG_W-1];
    div_req.mag     = diff[MAG_W-1] ? (~diff + 1'b1) : diff;
    div_req.divisor = div_len;
  end

  tle_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // Sequencer: IDLE takes a tick, DIV waits on the divider, STEP advances the
  // envelope by one sample, FIN moves the result into the output register.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (trigger_i && !div_len_zero) ? ST_DIV : ST_STEP;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = post_step_q ? ST_STEP : ST_FIN;
        end
      end
      ST_STEP: begin
        state_d = (step_div && !div_len_zero) ? ST_DIV : ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    accept     = in_ready_o && in_valid_i;
    div_go     = (accept && trigger_i && !div_len_zero)
              || ((state_q == ST_STEP) && step_div && !div_len_zero);
    out_load   = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  end

  // Envelope state updates.
  always_comb begin
    acc_d       = acc_q;
    slope_d     = slope_q;
    cnt_d       = cnt_q;
    seg_d       = seg_q;
    run_d       = run_q;
    post_step_d = post_step_q;

    if (accept && trigger_i) begin
      // Restart: load the first level, clear position, and fetch the slope.
      acc_d       = {lvl_q[0], {FRAC_SH{1'b0}}};
      run_d       = 1'b1;
      seg_d       = '0;
      cnt_d       = '0;
      post_step_d = 1'b1;
      if (div_len_zero) begin
        slope_d = '0;
      end
    end

    if (state_q == ST_STEP) begin
      if (seg_live) begin
        if (cnt_lt) begin
          acc_d = acc_sat;
          cnt_d = cnt_q + 1'b1;
        end else begin
          // End of the segment: this tick holds the level.
          seg_d       = seg_nxt;
          cnt_d       = '0;
          post_step_d = 1'b0;
          if (nxt_live && div_len_zero) begin
            slope_d = '0;
          end
        end
      end else begin
        // Idle or finished: park on the final breakpoint level.
        run_d = 1'b0;
        cnt_d = '0;
        seg_d = '0;
        acc_d = {lvl_q[used], {FRAC_SH{1'b0}}};
      end
    end

    if ((state_q == ST_DIV) && div_rsp.done) begin
      slope_d = div_rsp.quot;
    end
  end

  // Output register: it frees the sequencer to take the next tick while the
  // current transaction waits on the output side.
  always_comb begin
    out_valid_d = out_valid_q;
    level_d     = level_q;
    play_d      = play_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      level_d     = acc_q[ACC_W-1:FRAC_SH];
      play_d      = run_q;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      slope_q     <= '0;
      cnt_q       <= '0;
      seg_q       <= '0;
      run_q       <= 1'b0;
      post_step_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      slope_q     <= slope_d;
      cnt_q       <= cnt_d;
      seg_q       <= seg_d;
      run_q       <= run_d;
      post_step_q <= post_step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
    play_q  <= play_d;
  end

  assign out_valid_o = out_valid_q;
  assign level_out_o = level_q;
  assign playing_o   = play_q;

endmodule

>>> design/tle_checker.sv
`include "triggered_linear_envelope_core_macros.svh"

module tle_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [tle_pkg::LVL_W-1:0]    level_out_o,
  input logic                         pready
);

  // An accepted tick always keeps the block busy in the cycle after it.
  `TLE_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)

  // A new result is registered on the same edge that frees the input side.
  `TLE_ASSERT(a_result_frees_input, clk_i, rst_ni, $rose(out_valid_o) |-> in_ready_o)

  // A stalled result holds its level until it is taken.
  `TLE_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(level_out_o))

  // Configuration accesses never wait.
  `TLE_ASSERT_ALWAYS(a_pready_high, clk_i, pready)

endmodule

bind triggered_linear_envelope_core tle_checker u_tle_checker (.*);
